// File: rtl/stsum_pkg.sv
// Shared types and constants for the segment tree range-sum block.
// No dependencies.
package stsum_pkg;
  localparam int unsigned LEVELS = 10;
  localparam int unsigned MAX_ELEMENTS = 1 << LEVELS;
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned LEN_BITS = LEVELS + 1;
  localparam int unsigned NODE_BITS = LEVELS + 1;

  localparam logic MODE_SET   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [NODE_BITS-1:0] node_t;

  typedef enum logic [1:0] {
    ST_CLEAR, ST_IDLE, ST_BUSY, ST_OUT
  } state_t;

  // lo/hi are positions within the current level; set tokens use lo only
  typedef struct packed {
    logic   mode;
    logic   active;
    node_t  lo;
    node_t  hi;
    value_t acc;
  } token_t;
endpackage

// File: rtl/stsum_level.sv
// One tree level cell that steps a set or query token up one level through
// its tok_r and out_tok_r registers, and the dual-read node RAM beside it. Depends on stsum_pkg.
module stsum_level import stsum_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   clr_en,
  input  node_t  clr_addr,
  input  logic   tok_in_vld,
  input  token_t tok_in,
  output logic   tok_out_vld,
  output token_t tok_out,
  output logic   ram_we,
  output node_t  ram_wa,
  output value_t ram_wd,
  output node_t  ram_ra,
  output node_t  ram_rb,
  input  value_t ram_rd_a,
  input  value_t ram_rd_b
);
  logic   vld_r, out_vld_r;
  token_t tok_r, out_tok_r, tok_nxt;
  node_t  lo_n, hi_n;
  value_t acc_n;

  // set: write own node, read sibling; query: read lo and hi-1
  always_comb begin
    ram_we = 1'b0;
    ram_wa = tok_in.lo;
    ram_wd = tok_in.acc;
    ram_ra = tok_in.lo;
    ram_rb = tok_in.hi - node_t'(1);
    if (tok_in.mode == MODE_SET) ram_rb = tok_in.lo ^ node_t'(1);
    if (clr_en) begin
      ram_we = 1'b1;
      ram_wa = clr_addr;
      ram_wd = '0;
    end else if (tok_in_vld && tok_in.mode == MODE_SET && tok_in.active) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    lo_n  = tok_r.lo;
    hi_n  = tok_r.hi;
    acc_n = tok_r.acc;
    if (tok_r.mode == MODE_SET) begin
      acc_n = tok_r.acc + ram_rd_b;
    end else if (tok_r.active && lo_n < hi_n) begin
      if (lo_n[0]) begin
        acc_n = acc_n + ram_rd_a;
        lo_n  = lo_n + node_t'(1);
      end
      if (hi_n[0]) begin
        hi_n  = hi_n - node_t'(1);
        acc_n = acc_n + ram_rd_b;
      end
    end
    tok_nxt     = tok_r;
    tok_nxt.lo  = lo_n >> 1;
    tok_nxt.hi  = hi_n >> 1;
    tok_nxt.acc = acc_n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      vld_r     <= tok_in_vld;
      out_vld_r <= vld_r;
    end
    if (tok_in_vld) tok_r <= tok_in;
    if (vld_r) out_tok_r <= tok_nxt;
  end

  assign tok_out_vld = out_vld_r;
  assign tok_out     = out_tok_r;
endmodule

module stsum_ram import stsum_pkg::*; #(
  parameter int unsigned AW = 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  value_t        wd,
  input  logic [AW-1:0] ra,
  input  logic [AW-1:0] rb,
  output value_t        rd_a,
  output value_t        rd_b
);
  value_t mem_r [1 << AW];
  value_t rd_a_r, rd_b_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[wa] <= wd;
    rd_a_r <= mem_r[ra];
    rd_b_r <= mem_r[rb];
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;
endmodule

// File: rtl/segment_tree_point_set_range_sum.sv
// Segment tree range sum with point set, one level cell per tree level.
// One item at a time: a token passes the entry register, then the tok_r and
// out_tok_r registers of each level cell from the leaves to the root, and the
// root accumulator lands in the exit register sum_r.
// Reset (rst_n low, synchronous) clears the control and sets length 1024; then a
// clearing pass, stepping clr_r over the node addresses, zeroes the node memories before in_ready rises.
// Depends on stsum_pkg, stsum_level and stsum_ram.
module segment_tree_point_set_range_sum import stsum_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_mode,
  input  logic [LEVELS-1:0]           in_index,
  input  logic signed [VALUE_BITS-1:0] in_new_value,
  input  logic [LEVELS-1:0]           in_range_start,
  input  logic [LEVELS-1:0]           in_range_end,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [VALUE_BITS-1:0] out_range_sum,
  input  logic                        cfg_we,
  input  logic [LEN_BITS-1:0]         cfg_wdata
);
  state_t state_r, state_nxt;
  logic [LEN_BITS-1:0] len_r, len_eff, last_pos;
  node_t  clr_r;
  logic   clr_en;
  value_t sum_r;
  logic   start;
  token_t tok0;
  logic   ent_vld_r;
  token_t ent_tok_r;

  logic   vld [LEVELS+2];
  token_t tk  [LEVELS+2];

  assign len_eff = (len_r > LEN_BITS'(MAX_ELEMENTS)) ? LEN_BITS'(MAX_ELEMENTS) : len_r;
  assign start   = in_valid && in_ready;

  // leaf-level entry token; leaves are level LEVELS
  always_comb begin
    last_pos = (LEN_BITS'(in_range_end) > len_eff - LEN_BITS'(1))
               ? len_eff - LEN_BITS'(1) : LEN_BITS'(in_range_end);
    tok0 = '0;
    tok0.mode = in_mode;
    if (in_mode == MODE_SET) begin
      tok0.lo     = node_t'(in_index);
      tok0.hi     = node_t'(in_index);
      tok0.acc    = value_t'(in_new_value);
      tok0.active = LEN_BITS'(in_index) < len_eff;
    end else begin
      tok0.lo     = node_t'(in_range_start);
      tok0.hi     = node_t'(last_pos) + node_t'(1);
      tok0.active = (len_eff != '0) && (LEN_BITS'(in_range_start) <= last_pos);
    end
  end

  assign vld[LEVELS+1] = ent_vld_r;
  assign tk[LEVELS+1]  = ent_tok_r;

  genvar g;
  generate
    for (g = 0; g <= LEVELS; g++) begin : g_lvl
      localparam int unsigned AW = (g == 0) ? 1 : g;
      logic   we;
      node_t  wa, ra, rb;
      value_t wd, rd_a, rd_b;
      stsum_level u_lvl (
        .clk, .rst_n, .clr_en, .clr_addr(clr_r),
        .tok_in_vld(vld[g+1]), .tok_in(tk[g+1]),
        .tok_out_vld(vld[g]), .tok_out(tk[g]),
        .ram_we(we), .ram_wa(wa), .ram_wd(wd), .ram_ra(ra), .ram_rb(rb),
        .ram_rd_a(rd_a), .ram_rd_b(rd_b)
      );
      stsum_ram #(.AW(AW)) u_ram (
        .clk, .we, .wa(wa[AW-1:0]), .wd, .ra(ra[AW-1:0]), .rb(rb[AW-1:0]),
        .rd_a, .rd_b
      );
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_r == node_t'(MAX_ELEMENTS - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (start) state_nxt = ST_BUSY;
      ST_BUSY:  if (vld[0]) state_nxt = (tk[0].mode == MODE_QUERY) ? ST_OUT : ST_IDLE;
      ST_OUT:   if (out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    clr_en    = 1'b0;
    case (state_r)
      ST_CLEAR: clr_en = 1'b1;
      ST_IDLE:  in_ready = 1'b1;
      ST_OUT:   out_valid = 1'b1;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_r     <= '0;
      len_r     <= LEN_BITS'(MAX_ELEMENTS);
      ent_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      if (cfg_we) len_r <= cfg_wdata;
      if (clr_en) clr_r <= clr_r + node_t'(1);
      ent_vld_r <= start;
    end
    if (start) ent_tok_r <= tok0;
    if (vld[0]) sum_r <= tk[0].acc;
  end

  assign out_range_sum = sum_r;
endmodule
